// ===== design/rpf_pkg.sv =====
`default_nettype none

package rpf_pkg;

  // default fraction width of the internal fixed-point coordinates
  localparam int FRAC_BITS = 16;

  localparam int KIND_W  = 3;
  localparam int RAND_W  = 16;
  localparam int COORD_W = 18;

  typedef enum logic [KIND_W-1:0] {
    KIND_EDGE    = 3'd0,
    KIND_TRI     = 3'd1,
    KIND_QUAD    = 3'd2,
    KIND_HEX     = 3'd3,
    KIND_PYRAMID = 3'd4,
    KIND_TET     = 3'd5,
    KIND_PRISM   = 3'd6,
    KIND_UNSUP   = 3'd7
  } kind_t;

endpackage

`default_nettype wire

// ===== design/rpf_if.sv =====
`default_nettype none

interface rpf_in_if;
  logic                             valid;
  logic                             ready;
  logic [rpf_pkg::KIND_W-1:0]       kind;
  logic [rpf_pkg::RAND_W-1:0]       rand_a;
  logic [rpf_pkg::RAND_W-1:0]       rand_b;
  logic [rpf_pkg::RAND_W-1:0]       rand_c;
  logic                             last_sample;

  modport source (output valid, kind, rand_a, rand_b, rand_c, last_sample, input ready);
  modport sink   (input valid, kind, rand_a, rand_b, rand_c, last_sample, output ready);
endinterface

interface rpf_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [rpf_pkg::COORD_W-1:0] coord_x;
  logic signed [rpf_pkg::COORD_W-1:0] coord_y;
  logic signed [rpf_pkg::COORD_W-1:0] coord_z;
  logic                               last_point;
  logic                               unsupported;

  modport source (output valid, coord_x, coord_y, coord_z, last_point, unsupported,
                  input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, last_point, unsupported,
                  output ready);
endinterface

`default_nettype wire

// ===== design/reference_element_point_fold_unit.sv =====
// Reference element point folder.
// in_ch carries one sample per transfer: element kind, three uniform
// numbers in [0,1) (Q0.16) and a last-sample flag. out_ch returns one point
// per sample: x, y, z in signed Q1.16 (unused axes zero), a copy of the
// last flag, and an unsupported flag for kind 7 (coordinates then zero).
// Both channels transfer when valid and ready are high at a clock edge.
// out_ch.valid rises in the cycle after an input transfer. Throughput: 1
// sample per cycle unless out_ch stalls. All folding (compares, swaps,
// adds) is combinational between the input port and the result register.
// in_ch.ready is high whenever the result register is empty or is being
// drained in the same cycle, so a stalled receiver holds the current point
// and back-pressures the sender; nothing is dropped.
// Reset (rst_n low, synchronous) empties the result register.
// FRAC_BITS sets the internal fraction width; the 18-bit outputs carry the
// low bits of the sign-extended internal value.
`default_nettype none

module reference_element_point_fold_unit #(
  parameter int FRAC_BITS = rpf_pkg::FRAC_BITS
) (
  input  wire        clk,
  input  wire        rst_n,
  rpf_in_if.sink     in_ch,
  rpf_out_if.source  out_ch
);

  localparam int W     = FRAC_BITS + 2;
  localparam int CW    = rpf_pkg::COORD_W;
  localparam int EXT_W = (W > CW) ? W : CW;

  localparam logic signed [W-1:0] ONE = signed'({2'b01, {FRAC_BITS{1'b0}}});

  function automatic logic signed [W-1:0] unit_of(input logic [rpf_pkg::RAND_W-1:0] u);
    logic [FRAC_BITS+rpf_pkg::RAND_W-1:0] wide;
    wide    = {u, {FRAC_BITS{1'b0}}};
    unit_of = signed'({2'b00, wide[FRAC_BITS+rpf_pkg::RAND_W-1:rpf_pkg::RAND_W]});
  endfunction

  function automatic logic signed [W-1:0] signed_unit(input logic [rpf_pkg::RAND_W-1:0] u);
    signed_unit = (unit_of(u) <<< 1) - ONE;
  endfunction

  function automatic logic signed [W-1:0] mag(input logic signed [W-1:0] v);
    mag = v[W-1] ? -v : v;
  endfunction

  function automatic logic signed [CW-1:0] to_out(input logic signed [W-1:0] v);
    logic signed [EXT_W-1:0] ext;
    ext    = EXT_W'(v);
    to_out = ext[CW-1:0];
  endfunction

  // Common axis values
  logic signed [W-1:0] ua, ub, sa, sb, sc;
  // Triangle fold
  logic signed [W-1:0] tx, ty;
  // Pyramid fold
  logic signed [W-1:0] ax, ay, az, px, py, pz, pz_sel;
  logic                pyr_in;
  // Tet fold
  logic signed [W-1:0] mx, my, hx, hy;

  logic signed [W-1:0] x, y, z;
  logic                bad;

  logic                out_valid_r, out_valid_nxt;
  logic signed [CW-1:0] coord_x_r, coord_y_r, coord_z_r;
  logic                last_point_r, unsupported_r;
  logic                in_xfer;

  always_comb begin
    ua = unit_of(in_ch.rand_a);
    ub = unit_of(in_ch.rand_b);
    sa = signed_unit(in_ch.rand_a);
    sb = signed_unit(in_ch.rand_b);
    sc = signed_unit(in_ch.rand_c);

    // mirror across x + y = 1 only when strictly outside
    if (ub > ONE - ua) begin
      tx = ONE - ua;
      ty = ONE - ub;
    end else begin
      tx = ua;
      ty = ub;
    end

    ax     = mag(sa);
    ay     = mag(sb);
    az     = mag(sc);
    pyr_in = (ax < az) && (ay < az);
    if (pyr_in) begin
      px     = sa;
      py     = sb;
      pz_sel = sc;
    end else if (ay > ax) begin
      px     = sa;
      py     = sc;
      pz_sel = sb;
    end else begin
      px     = sb;
      py     = sc;
      pz_sel = sa;
    end
    pz = ONE - mag(pz_sel);

    mx = mag(px);
    my = mag(py);
    if (my > mx) begin
      hx = my;
      hy = mx;
    end else begin
      hx = mx;
      hy = my;
    end

    x   = '0;
    y   = '0;
    z   = '0;
    bad = 1'b0;
    case (rpf_pkg::kind_t'(in_ch.kind))
      rpf_pkg::KIND_EDGE: begin
        x = sa;
      end
      rpf_pkg::KIND_TRI: begin
        x = tx;
        y = ty;
      end
      rpf_pkg::KIND_QUAD: begin
        x = sa;
        y = sb;
      end
      rpf_pkg::KIND_HEX: begin
        x = sa;
        y = sb;
        z = sc;
      end
      rpf_pkg::KIND_PYRAMID: begin
        x = px;
        y = py;
        z = pz;
      end
      rpf_pkg::KIND_TET: begin
        x = hx - hy;
        y = hy;
        z = pz;
      end
      rpf_pkg::KIND_PRISM: begin
        x = tx;
        y = ty;
        z = sc;
      end
      default: begin
        bad = 1'b1;
      end
    endcase
  end

  assign in_ch.ready   = !out_valid_r || out_ch.ready;
  assign in_xfer       = in_ch.valid && in_ch.ready;
  assign out_valid_nxt = in_xfer ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      coord_x_r     <= to_out(x);
      coord_y_r     <= to_out(y);
      coord_z_r     <= to_out(z);
      last_point_r  <= in_ch.last_sample;
      unsupported_r <= bad;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.coord_x     = coord_x_r;
  assign out_ch.coord_y     = coord_y_r;
  assign out_ch.coord_z     = coord_z_r;
  assign out_ch.last_point  = last_point_r;
  assign out_ch.unsupported = unsupported_r;

endmodule

`default_nettype wire

// ===== design/rpf_checker.sv =====
`default_nettype none

module rpf_checker (
  input wire                               clk,
  input wire                               rst_n,
  input wire                               in_valid,
  input wire                               in_ready,
  input wire                               in_last_sample,
  input wire                               out_valid,
  input wire                               out_ready,
  input wire signed [rpf_pkg::COORD_W-1:0] out_coord_x,
  input wire signed [rpf_pkg::COORD_W-1:0] out_coord_y,
  input wire signed [rpf_pkg::COORD_W-1:0] out_coord_z,
  input wire                               out_last_point,
  input wire                               out_unsupported
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // every input transfer shows up as a result on the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid && out_last_point == $past(in_last_sample))
    else $error("result missing or last flag wrong after input transfer");

  // empty result register never back-pressures
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_unsup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_unsupported |->
      out_coord_x == '0 && out_coord_y == '0 && out_coord_z == '0)
    else $error("unsupported kind with nonzero coordinates");

endmodule

bind reference_element_point_fold_unit rpf_checker u_rpf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_last_sample  (in_ch.last_sample),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_coord_x     (out_ch.coord_x),
  .out_coord_y     (out_ch.coord_y),
  .out_coord_z     (out_ch.coord_z),
  .out_last_point  (out_ch.last_point),
  .out_unsupported (out_ch.unsupported)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rpf_pkg::*;

  localparam int RANDOM_ITEMS = 900;
  // no new idle gaps start on either side once this few items are left
  localparam int QUIET_TAIL   = 120;

  // wide enough for 2u and every intermediate sum
  typedef logic signed [COORD_W+1:0] fix_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [RAND_W-1:0]         unit_t;

  localparam fix_t UNIT_ONE = fix_t'(1) <<< FRAC_BITS;

  typedef struct {
    kind_t kind;
    unit_t a;
    unit_t b;
    unit_t c;
    logic  last;
    bit    hold;   // wait for all outstanding points before offering this one
  } sample_t;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
    logic   unsup;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rpf_in_if  in_ch();
  rpf_out_if out_ch();

  reference_element_point_fold_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  sample_t pending[$];
  point_t  fold_expect[$];
  sample_t on_wire;
  int      send_gap;
  int      recv_stall;
  int      err_count;

  // ---------------------------------------------------------------- predictor

  // FRAC_BITS >= 16: Q0.16 input maps exactly
  function automatic fix_t from_unit(unit_t u);
    return fix_t'({4'b0, u}) <<< (FRAC_BITS - 16);
  endfunction

  function automatic fix_t centered(unit_t u);
    return (from_unit(u) <<< 1) - UNIT_ONE;
  endfunction

  function automatic fix_t mag(fix_t v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void fold_into_pyramid(inout fix_t x, inout fix_t y, inout fix_t z);
    fix_t t;
    if (!(mag(x) < mag(z) && mag(y) < mag(z))) begin
      if (mag(y) > mag(x)) begin
        t = y;
        y = z;
        z = t;
      end else begin
        t = x;
        x = y;
        y = z;
        z = t;
      end
    end
    z = UNIT_ONE - mag(z);
  endfunction

  function automatic void fold_into_triangle(inout fix_t x, inout fix_t y);
    if (y > UNIT_ONE - x) begin
      x = UNIT_ONE - x;
      y = UNIT_ONE - y;
    end
  endfunction

  function automatic point_t fold_point(sample_t s);
    fix_t   x;
    fix_t   y;
    fix_t   z;
    fix_t   t;
    point_t p;
    x = 0;
    y = 0;
    z = 0;
    p.unsup = 1'b0;
    case (s.kind)
      KIND_EDGE: begin
        x = centered(s.a);
      end
      KIND_TRI: begin
        x = from_unit(s.a);
        y = from_unit(s.b);
        fold_into_triangle(x, y);
      end
      KIND_QUAD: begin
        x = centered(s.a);
        y = centered(s.b);
      end
      KIND_HEX: begin
        x = centered(s.a);
        y = centered(s.b);
        z = centered(s.c);
      end
      KIND_PYRAMID: begin
        x = centered(s.a);
        y = centered(s.b);
        z = centered(s.c);
        fold_into_pyramid(x, y, z);
      end
      KIND_TET: begin
        x = centered(s.a);
        y = centered(s.b);
        z = centered(s.c);
        fold_into_pyramid(x, y, z);
        x = mag(x);
        y = mag(y);
        if (y > x) begin
          t = x;
          x = y;
          y = t;
        end
        x = x - y;
      end
      KIND_PRISM: begin
        x = from_unit(s.a);
        y = from_unit(s.b);
        z = centered(s.c);
        fold_into_triangle(x, y);
      end
      default: begin
        p.unsup = 1'b1;
      end
    endcase
    p.x    = coord_t'(x);
    p.y    = coord_t'(y);
    p.z    = coord_t'(z);
    p.last = s.last;
    return p;
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic add_sample(kind_t k, unit_t a, unit_t b, unit_t c, logic last, bit hold);
    sample_t s;
    s.kind = k;
    s.a    = a;
    s.b    = b;
    s.c    = c;
    s.last = last;
    s.hold = hold;
    pending.push_back(s);
  endtask

  function automatic unit_t rand_unit();
    case ($urandom_range(0, 11))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return unit_t'($urandom_range(16'h7FFF, 16'h8001));
      default: return unit_t'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        fold_expect.push_back(fold_point(on_wire));
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending.size() != 0 && !(pending[0].hold && fold_expect.size() != 0)) begin
          on_wire = pending.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.kind        <= on_wire.kind;
          in_ch.rand_a      <= on_wire.a;
          in_ch.rand_b      <= on_wire.b;
          in_ch.rand_c      <= on_wire.c;
          in_ch.last_sample <= on_wire.last;
          if (pending.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 4);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    point_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (fold_expect.size() == 0) begin
          $error("point transfer with no sample outstanding: x=%0d y=%0d z=%0d",
                 out_ch.coord_x, out_ch.coord_y, out_ch.coord_z);
          err_count++;
        end else begin
          want = fold_expect.pop_front();
          check_field("coord_x", want.x, out_ch.coord_x);
          check_field("coord_y", want.y, out_ch.coord_y);
          check_field("coord_z", want.z, out_ch.coord_z);
          check_field("last_point", want.last, out_ch.last_point);
          check_field("unsupported", want.unsup, out_ch.unsupported);
        end
      end
      if (recv_stall > 0) begin
        recv_stall = recv_stall - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (pending.size() > QUIET_TAIL && $urandom_range(0, 6) == 0) begin
          recv_stall = $urandom_range(1, 4);
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    kind_t k;
    unit_t a;
    unit_t b;
    unit_t c;
    err_count         = 0;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_EDGE;
    in_ch.rand_a      = '0;
    in_ch.rand_b      = '0;
    in_ch.rand_c      = '0;
    in_ch.last_sample = 1'b0;
    out_ch.ready      = 1'b0;

    // directed: field extremes, each kind, strict-compare ties
    add_sample(KIND_EDGE,    16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
    add_sample(KIND_EDGE,    16'hFFFF, 16'h0000, 16'h0000, 1'b1, 1'b0);
    add_sample(KIND_QUAD,    16'h0000, 16'hFFFF, 16'h1234, 1'b0, 1'b0);
    add_sample(KIND_QUAD,    16'hFFFF, 16'h0000, 16'h0000, 1'b1, 1'b0);
    add_sample(KIND_HEX,     16'h0000, 16'h8000, 16'hFFFF, 1'b0, 1'b0);
    add_sample(KIND_TRI,     16'h8000, 16'h8000, 16'hFFFF, 1'b0, 1'b0); // on the diagonal
    add_sample(KIND_TRI,     16'h8001, 16'h8000, 16'h0000, 1'b1, 1'b0); // just past it
    add_sample(KIND_TRI,     16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b0);
    add_sample(KIND_TRI,     16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
    add_sample(KIND_PRISM,   16'h8001, 16'h8000, 16'h0000, 1'b0, 1'b0);
    add_sample(KIND_PRISM,   16'h4000, 16'h4000, 16'hFFFF, 1'b1, 1'b0);
    add_sample(KIND_PYRAMID, 16'h8000, 16'h8000, 16'h0000, 1'b0, 1'b0); // already inside
    add_sample(KIND_PYRAMID, 16'h4000, 16'h8000, 16'hC000, 1'b0, 1'b0); // |x| == |z|
    add_sample(KIND_PYRAMID, 16'h4000, 16'hC000, 16'h8000, 1'b0, 1'b0); // |y| == |x|
    add_sample(KIND_PYRAMID, 16'h8000, 16'hF000, 16'h9000, 1'b1, 1'b0); // |y| > |x|
    add_sample(KIND_PYRAMID, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
    add_sample(KIND_PYRAMID, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
    add_sample(KIND_TET,     16'h6000, 16'hA000, 16'h0000, 1'b0, 1'b0); // |x| == |y|
    add_sample(KIND_TET,     16'h9000, 16'hC000, 16'h0000, 1'b0, 1'b0); // y > x
    add_sample(KIND_TET,     16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0);
    add_sample(KIND_TET,     16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
    add_sample(KIND_UNSUP,   16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    add_sample(KIND_UNSUP,   16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      k = kind_t'($urandom_range(0, 7));
      a = rand_unit();
      b = rand_unit();
      c = rand_unit();
      // bias toward the folding ties: mirrored diagonal, equal magnitudes
      case ($urandom_range(0, 3))
        0: begin
          if (k == KIND_TRI || k == KIND_PRISM) begin
            b = unit_t'(65536 - int'(a) + int'($urandom_range(0, 2)) - 1);
          end else begin
            b = $urandom_range(0, 1) ? a : unit_t'(-a);
          end
        end
        1: c = $urandom_range(0, 1) ? a : unit_t'(-a);
        2: c = $urandom_range(0, 1) ? b : unit_t'(-b);
        default: ;
      endcase
      add_sample(k, a, b, c, logic'($urandom_range(0, 1)), n == 0 || n == RANDOM_ITEMS / 2);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_ch.valid) @(posedge clk);
    while (fold_expect.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (err_count == 0) begin
      $display("reference_element_point_fold_unit regression: pass");
    end else begin
      $display("reference_element_point_fold_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("reference_element_point_fold_unit regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
